// ===== rtl/core/dwpv_pkg.sv =====
// shared types and constants for the dual wheel pi velocity control unit
`default_nettype none

package dwpv_pkg;

  localparam int SUM_WIDTH = 32;
  localparam int PP_W      = 34;
  localparam int PI_W      = SUM_WIDTH + 17;
  localparam int ACC_W     = ((PI_W > PP_W) ? PI_W : PP_W) + 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_FLD_W  = 98;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [1:0] REG_SPEED_SCALE  = 2'd0;
  localparam logic [1:0] REG_PROP_GAIN    = 2'd1;
  localparam logic [1:0] REG_INT_GAIN     = 2'd2;
  localparam logic [1:0] REG_EFFORT_LIMIT = 2'd3;

  typedef struct packed {
    logic [15:0] speed_scale;
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [14:0] effort_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] effort;
    logic signed [16:0] err;
    logic signed [15:0] speed;
  } lane_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/dual_wheel_pi_velocity_control_unit.sv =====
// top level of the dual wheel pi velocity control unit
// usage:
//   s_* carries one control interval per item: both encoder counts, both
//   target speeds, and the restart flag in s_tuser that clears both error sums.
//   m_* returns one item per input: efforts, speed errors and measured speeds.
//   cfg_we/cfg_addr/cfg_wdata write speed_scale, prop_gain, int_gain and
//   effort_limit (indexes 0..3); write only while no item is in flight.
// timing:
//   two lanes (left, right) run in lockstep through an eight step sequence
//   with one multiplier each per step; m_tvalid rises once both lanes are done.
//   s_tready rises at the edge where the result moves into the output
//   register, so a new item is taken only once the last has moved out of the lanes.
// reset:
//   rst (synchronous) restores the default registers, clears stored counts
//   and error sums, and empties the output register.
// stall:
//   a held result waits in the output register while the next item is worked
//   on; the lanes then hold their result until the output register frees up.
`default_nettype none

module dual_wheel_pi_velocity_control_unit
  import dwpv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // enc_left, enc_right, goal_left, goal_right
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // restart
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // effort_left, effort_right, err_left, err_right, speed_left, speed_right, zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [15:0]           cfg_wdata
);

  cfg_t       cfg;
  lane_res_t  res_left;
  lane_res_t  res_right;
  lane_stat_t stat_left;
  lane_stat_t stat_right;
  logic       start;
  logic       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_scale  <= 16'd782;
      cfg.prop_gain    <= 16'd256;
      cfg.int_gain     <= 16'd0;
      cfg.effort_limit <= 15'd300;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SPEED_SCALE:  cfg.speed_scale  <= cfg_wdata;
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_wdata;
        REG_INT_GAIN:     cfg.int_gain     <= cfg_wdata;
        REG_EFFORT_LIMIT: cfg.effort_limit <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = stat_left.idle & stat_right.idle;
  assign start    = s_tvalid & s_tready;

  dwpv_lane u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .take    (take),
    .enc     (s_tdata[15:0]),
    .goal    ($signed(s_tdata[47:32])),
    .restart (s_tuser),
    .cfg     (cfg),
    .res     (res_left),
    .stat    (stat_left)
  );

  dwpv_lane u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .take    (take),
    .enc     (s_tdata[31:16]),
    .goal    ($signed(s_tdata[63:48])),
    .restart (s_tuser),
    .cfg     (cfg),
    .res     (res_right),
    .stat    (stat_right)
  );

  dwpv_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .res_left   (res_left),
    .res_right  (res_right),
    .stat_left  (stat_left),
    .stat_right (stat_right),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dwpv_lane.sv =====
// one wheel lane: count delta, speed scaling, error sum and pi effort
`default_nettype none

module dwpv_lane
  import dwpv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               take,
  input  wire logic [15:0]        enc,
  input  wire logic signed [15:0] goal,
  input  wire logic               restart,
  input  wire cfg_t               cfg,
  output lane_res_t               res,
  output lane_stat_t              stat
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_SPD = 4'd1;
  localparam logic [3:0] S_SPEED   = 4'd2;
  localparam logic [3:0] S_SUM     = 4'd3;
  localparam logic [3:0] S_MUL_P   = 4'd4;
  localparam logic [3:0] S_MUL_I   = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_CLAMP   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam logic signed [32:0] SPD_HI = 33'sd32767;
  localparam logic signed [32:0] SPD_LO = -33'sd32768;
  localparam logic signed [SUM_WIDTH+1:0] SUM_HI = {3'b000, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH+1:0] SUM_LO = {3'b111, {(SUM_WIDTH-1){1'b0}}};

  logic [3:0]                  state;
  logic [15:0]                 last_count;
  logic signed [15:0]          delta;
  logic signed [15:0]          goal_q;
  logic                        restart_q;
  logic signed [32:0]          prod_spd;
  logic signed [15:0]          speed;
  logic signed [16:0]          err;
  logic signed [SUM_WIDTH-1:0] sum;
  logic signed [PP_W-1:0]      prod_p;
  logic signed [PI_W-1:0]      prod_i;
  logic signed [ACC_W-1:0]     acc;
  logic signed [15:0]          effort;

  logic signed [32:0]          spd_shift;
  logic signed [15:0]          speed_sat;
  logic signed [16:0]          err_next;
  logic signed [SUM_WIDTH-1:0] sum_base;
  logic signed [SUM_WIDTH+1:0] sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [ACC_W-1:0]     lim_pos;
  logic signed [ACC_W-1:0]     lim_neg;
  logic signed [15:0]          effort_next;

  // speed from scaled delta, floor by arithmetic shift, saturated to 16 bits; then speed error
  always_comb begin
    spd_shift = prod_spd >>> 8;
    if (spd_shift > SPD_HI) begin
      speed_sat = 16'sh7fff;
    end else if (spd_shift < SPD_LO) begin
      speed_sat = -16'sh8000;
    end else begin
      speed_sat = spd_shift[15:0];
    end
    err_next = 17'(goal_q) - 17'(speed_sat);
  end

  // saturating error sum
  always_comb begin
    sum_base = restart_q ? '0 : sum;
    sum_wide = (SUM_WIDTH+2)'(sum_base) + (SUM_WIDTH+2)'(err);
    if (sum_wide > SUM_HI) begin
      sum_next = SUM_HI[SUM_WIDTH-1:0];
    end else if (sum_wide < SUM_LO) begin
      sum_next = SUM_LO[SUM_WIDTH-1:0];
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // effort clamp
  always_comb begin
    acc_q   = acc >>> 8;
    lim_pos = ACC_W'($signed({1'b0, cfg.effort_limit}));
    lim_neg = -lim_pos;
    if (acc_q > lim_pos) begin
      effort_next = lim_pos[15:0];
    end else if (acc_q < lim_neg) begin
      effort_next = lim_neg[15:0];
    end else begin
      effort_next = acc_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_count <= '0;
      sum        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            delta      <= $signed(enc - last_count);
            last_count <= enc;
            goal_q     <= goal;
            restart_q  <= restart;
            state      <= S_MUL_SPD;
          end
        end
        S_MUL_SPD: begin
          prod_spd <= 33'(delta) * 33'($signed({1'b0, cfg.speed_scale}));
          state    <= S_SPEED;
        end
        S_SPEED: begin
          speed <= speed_sat;
          err   <= err_next;
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= sum_next;
          state <= S_MUL_P;
        end
        S_MUL_P: begin
          prod_p <= PP_W'($signed({1'b0, cfg.prop_gain})) * PP_W'(err);
          state  <= S_MUL_I;
        end
        S_MUL_I: begin
          prod_i <= PI_W'($signed({1'b0, cfg.int_gain})) * PI_W'(sum);
          state  <= S_ACC;
        end
        S_ACC: begin
          acc   <= ACC_W'(prod_p) + ACC_W'(prod_i);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          effort <= effort_next;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.effort = effort;
  assign res.err    = err;
  assign res.speed  = speed;
  assign stat.idle  = (state == S_IDLE);
  assign stat.done  = (state == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/dwpv_merge.sv =====
// merge stage: joins both lane results into the output item register
`default_nettype none

module dwpv_merge
  import dwpv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lane_res_t             res_left,
  input  wire lane_res_t             res_right,
  input  wire lane_stat_t            stat_left,
  input  wire lane_stat_t            stat_right,
  output logic                       take,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic [OUT_FLD_W-1:0] packed_res;

  assign packed_res = {res_right.speed, res_left.speed, res_right.err, res_left.err,
                       res_right.effort, res_left.effort};
  assign take = stat_left.done & stat_right.done & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= OUT_DATA_W'(packed_res);
    end
  end

endmodule

`default_nettype wire
